// ----- hdl/ndsag_pkg.sv -----
// shared types, widths and codes for the strided copy address generator
`timescale 1ns / 1ps

package ndsag_pkg;

    // sizes
    localparam int MAX_RANK = 8;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 16;
    localparam int AXIS_W   = 3;
    localparam int RANKF_W  = 4;
    localparam int ELEM_W   = 13;
    localparam int RUN_W    = 28;
    localparam int KIND_W   = 2;
    localparam int RANK_W   = $clog2(MAX_RANK + 1);
    localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int PROD_W   = CNT_W + ELEM_W;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // command codes
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

    // input word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [AXIS_W-1:0]  axis;
        logic [ADDR_W-1:0]  src_stride;
        logic [CNT_W-1:0]   src_start;
        logic [ADDR_W-1:0]  dst_stride;
        logic [CNT_W-1:0]   dst_start;
        logic [CNT_W-1:0]   extent;
        logic [RANKF_W-1:0] rank;
        logic [ELEM_W-1:0]  elem_bytes;
        logic [ADDR_W-1:0]  src_base;
        logic [ADDR_W-1:0]  dst_base;
    } cmd_t;

    // result word
    typedef struct packed {
        logic              valid_res;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [RUN_W-1:0]  run_len;
        logic              last;
    } res_t;

    // axis table write broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [AXIS_W-1:0] axis;
        logic [ADDR_W-1:0] src_stride;
        logic [CNT_W-1:0]  src_start;
        logic [ADDR_W-1:0] dst_stride;
        logic [CNT_W-1:0]  dst_start;
        logic [CNT_W-1:0]  extent;
    } axis_load_t;

    // token handed from cell to cell, outermost-but-inner first
    typedef struct packed {
        logic              vld;
        logic              step;
        logic              carry;
        logic              zero;
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  ext;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } chain_tok_t;

endpackage

// ----- hdl/ndsag_cell.sv -----
// one axis cell: table entry, cursor and its part of the address sums
`timescale 1ns / 1ps

module ndsag_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ndsag_pkg::IDX_W-1:0]   idx,
    input  ndsag_pkg::axis_load_t         ld,
    input  ndsag_pkg::chain_tok_t         tok_in,
    output ndsag_pkg::chain_tok_t         tok_out
);

    logic [ndsag_pkg::ADDR_W-1:0] src_stride_reg;
    logic [ndsag_pkg::CNT_W-1:0]  src_start_reg;
    logic [ndsag_pkg::ADDR_W-1:0] dst_stride_reg;
    logic [ndsag_pkg::CNT_W-1:0]  dst_start_reg;
    logic [ndsag_pkg::CNT_W-1:0]  extent_reg;

    logic [ndsag_pkg::ADDR_W-1:0] src_off_reg;
    logic [ndsag_pkg::ADDR_W-1:0] dst_off_reg;
    logic [ndsag_pkg::ADDR_W-1:0] src_wrap_reg;
    logic [ndsag_pkg::ADDR_W-1:0] dst_wrap_reg;

    logic [ndsag_pkg::CNT_W-1:0]  cursor_reg;
    logic [ndsag_pkg::CNT_W-1:0]  cursor_next;
    ndsag_pkg::chain_tok_t        tok_reg;
    ndsag_pkg::chain_tok_t        tok_next;

    logic [ndsag_pkg::CNT_W:0]    cnt_inc;
    logic                         hit;
    int                           k;
    int                           r;

    assign hit = ld.en && (32'(ld.axis) == 32'(idx));

    // axis table entry
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            src_stride_reg <= ld.src_stride;
            src_start_reg  <= ld.src_start;
            dst_stride_reg <= ld.dst_stride;
            dst_start_reg  <= ld.dst_start;
            extent_reg     <= ld.extent;
        end
    end

    // start offset and rewind step, kept ready from the stored entry
    always_ff @(posedge clk)
    begin
        src_off_reg  <= ndsag_pkg::ADDR_W'(src_start_reg) * src_stride_reg;
        dst_off_reg  <= ndsag_pkg::ADDR_W'(dst_start_reg) * dst_stride_reg;
        src_wrap_reg <= src_stride_reg
                        * (ndsag_pkg::ADDR_W'(1) - ndsag_pkg::ADDR_W'(extent_reg));
        dst_wrap_reg <= dst_stride_reg
                        * (ndsag_pkg::ADDR_W'(1) - ndsag_pkg::ADDR_W'(extent_reg));
    end

    // work on the passing token
    always_comb
    begin
        k           = 32'(idx);
        r           = 32'(tok_in.rank);
        cnt_inc     = {1'b0, cursor_reg} + (ndsag_pkg::CNT_W + 1)'(1);
        tok_next    = tok_in;
        cursor_next = cursor_reg;
        if (tok_in.vld)
        begin
            if (!tok_in.step)
            begin
                // start: add this axis offset, clear cursor, note zero extents
                if (k < r)
                begin
                    tok_next.src = tok_in.src + src_off_reg;
                    tok_next.dst = tok_in.dst + dst_off_reg;
                    cursor_next  = '0;
                end
                if ((k + 1 < r) && (extent_reg == '0))
                    tok_next.zero = 1'b1;
                if (k + 1 == r)
                    tok_next.ext = extent_reg;
            end
            else if ((k + 2 <= r) && tok_in.carry)
            begin
                // step: bump cursor, or rewind and carry on
                if (cnt_inc < {1'b0, extent_reg})
                begin
                    cursor_next    = cnt_inc[ndsag_pkg::CNT_W-1:0];
                    tok_next.src   = tok_in.src + src_stride_reg;
                    tok_next.dst   = tok_in.dst + dst_stride_reg;
                    tok_next.carry = 1'b0;
                end
                else
                begin
                    cursor_next  = '0;
                    tok_next.src = tok_in.src + src_wrap_reg;
                    tok_next.dst = tok_in.dst + dst_wrap_reg;
                end
            end
        end
    end

    // cursor and token registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hdl/nd_strided_copy_address_generator_unit.sv -----
// top level: command decode, cell chain and result register
`timescale 1ns / 1ps

// Strided copy address generator. Load, idle-step and unknown commands need no walk:
// the result word strobes on done in the cycle after start is taken and the
// next command may follow straight away. A start or a step of a running walk sends a
// token down the chain of MAX_RANK axis cells, one cell per cycle, and busy stays
// high until the token has left the last cell; done strobes as busy falls. Every
// command gives exactly one result word on done, which holds for that single cycle
// only: the receiver must take it then, as there is no way to stall the output.
module nd_strided_copy_address_generator_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ndsag_pkg::cmd_t cmd,
    output logic            done,
    output ndsag_pkg::res_t res
);

    ndsag_pkg::chain_tok_t        tok_chain [0:ndsag_pkg::MAX_RANK];
    ndsag_pkg::chain_tok_t        tok_reg;
    ndsag_pkg::chain_tok_t        tok_next;
    ndsag_pkg::axis_load_t        ld;
    ndsag_pkg::chain_tok_t        fin;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    ndsag_pkg::res_t              res_reg, res_next;
    logic                         walking_reg, walking_next;
    logic [ndsag_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic [ndsag_pkg::ELEM_W-1:0] elem_reg, elem_next;
    logic [ndsag_pkg::ADDR_W-1:0] cur_src_reg, cur_src_next;
    logic [ndsag_pkg::ADDR_W-1:0] cur_dst_reg, cur_dst_next;
    logic [ndsag_pkg::RUN_W-1:0]  run_reg, run_next;
    logic [ndsag_pkg::PROD_W-1:0] run_full;
    logic                         accept;

    assign accept = start && !busy_reg;
    assign fin    = tok_chain[0];

    // table write broadcast
    always_comb
    begin
        ld.en         = accept && (cmd.kind == ndsag_pkg::KIND_LOAD);
        ld.axis       = cmd.axis;
        ld.src_stride = cmd.src_stride;
        ld.src_start  = cmd.src_start;
        ld.dst_stride = cmd.dst_stride;
        ld.dst_start  = cmd.dst_start;
        ld.extent     = cmd.extent;
    end

    // run length from the innermost extent, saturated
    assign run_full = ndsag_pkg::PROD_W'(fin.ext) * ndsag_pkg::PROD_W'(elem_reg);

    // command decode and walk completion
    always_comb
    begin
        tok_next     = '0;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        res_next     = '0;
        walking_next = walking_reg;
        rank_next    = rank_reg;
        elem_next    = elem_reg;
        cur_src_next = cur_src_reg;
        cur_dst_next = cur_dst_reg;
        run_next     = run_reg;

        if (accept)
        begin
            case (cmd.kind)
                ndsag_pkg::KIND_START:
                begin
                    if (cmd.rank == '0)
                        rank_next = ndsag_pkg::RANK_W'(1);
                    else if (32'(cmd.rank) > ndsag_pkg::MAX_RANK)
                        rank_next = ndsag_pkg::RANK_W'(ndsag_pkg::MAX_RANK);
                    else
                        rank_next = ndsag_pkg::RANK_W'(cmd.rank);
                    elem_next      = cmd.elem_bytes;
                    tok_next.vld   = 1'b1;
                    tok_next.carry = 1'b1;
                    tok_next.rank  = rank_next;
                    tok_next.src   = cmd.src_base;
                    tok_next.dst   = cmd.dst_base;
                    busy_next      = 1'b1;
                end
                ndsag_pkg::KIND_STEP:
                begin
                    if (walking_reg)
                    begin
                        tok_next.vld   = 1'b1;
                        tok_next.step  = 1'b1;
                        tok_next.carry = 1'b1;
                        tok_next.rank  = rank_reg;
                        tok_next.src   = cur_src_reg;
                        tok_next.dst   = cur_dst_reg;
                        busy_next      = 1'b1;
                    end
                    else
                        done_next = 1'b1;
                end
                default:
                    done_next = 1'b1;
            endcase
        end

        // token leaves the last cell
        if (fin.vld)
        begin
            busy_next    = 1'b0;
            done_next    = 1'b1;
            cur_src_next = fin.src;
            cur_dst_next = fin.dst;
            if (fin.step)
            begin
                res_next.valid_res = 1'b1;
                res_next.src_addr  = cur_src_reg;
                res_next.dst_addr  = cur_dst_reg;
                res_next.run_len   = run_reg;
                res_next.last      = fin.carry;
                walking_next       = !fin.carry;
            end
            else
            begin
                if (run_full > ndsag_pkg::PROD_W'(ndsag_pkg::RUN_MAX))
                    run_next = ndsag_pkg::RUN_MAX;
                else
                    run_next = run_full[ndsag_pkg::RUN_W-1:0];
                walking_next = !fin.zero;
            end
        end
    end

    // control and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            walking_reg <= 1'b0;
            rank_reg    <= ndsag_pkg::RANK_W'(1);
            cur_src_reg <= '0;
            cur_dst_reg <= '0;
            run_reg     <= '0;
        end
        else
        begin
            tok_reg     <= tok_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            walking_reg <= walking_next;
            rank_reg    <= rank_next;
            cur_src_reg <= cur_src_next;
            cur_dst_reg <= cur_dst_next;
            run_reg     <= run_next;
        end
    end

    // result word and element size
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        elem_reg <= elem_next;
    end

    // chain of axis cells, token enters at the highest axis
    assign tok_chain[ndsag_pkg::MAX_RANK] = tok_reg;

    for (genvar i = 0; i < ndsag_pkg::MAX_RANK; i++)
    begin : g_cell
        ndsag_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .idx    (ndsag_pkg::IDX_W'(i)),
            .ld     (ld),
            .tok_in (tok_chain[i+1]),
            .tok_out(tok_chain[i])
        );
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;

endmodule
